// File: hw/rtl/gwss_pkg.sv
// ----------------------------------------------------------------------------
// gwss_pkg
// Types, constants and helper functions shared by the grid step sampler.
// ----------------------------------------------------------------------------
package gwss_pkg;

   localparam int GRID_SIZE   = 16;
   localparam int FIELD_CELLS = 16;
   localparam int EDGE        = (GRID_SIZE < FIELD_CELLS) ? GRID_SIZE : FIELD_CELLS;
   localparam logic [4:0] EDGE_LIM = 5'(EDGE);

   localparam int NUM_DIRS = 4;
   localparam int LANE_W   = 15;
   localparam int ENTRY_W  = NUM_DIRS * LANE_W;
   localparam int ADDR_W   = 8;
   localparam int DEPTH    = 256;
   localparam int CUM_W    = 17;
   localparam int PROD_W   = 33;
   localparam int FRAC_W   = 16;

   typedef enum logic {
      CMD_LOAD,
      CMD_STEP
   } cmd_type;

   typedef enum logic [1:0] {
      DIR_LEFT,
      DIR_RIGHT,
      DIR_UP,
      DIR_DOWN
   } dir_type;

   // One lane write into the weight store.
   typedef struct packed {
      logic                en;
      logic [ADDR_W-1:0]   addr;
      dir_type             lane;
      logic [LANE_W-1:0]   data;
   } wr_req_type;

   // Step operands after the scaling multiply.
   typedef struct packed {
      logic [3:0]          row;
      logic [3:0]          col;
      logic                on_grid;
      logic [CUM_W-1:0]    cum0;
      logic [CUM_W-1:0]    cum1;
      logic [CUM_W-1:0]    cum2;
      logic [CUM_W-1:0]    cum3;
      logic [PROD_W-1:0]   thresh;
   } pick_op_type;

   typedef struct packed {
      logic                moved;
      dir_type             dir;
      logic [3:0]          row;
      logic [3:0]          col;
   } pick_res_type;

   // Magnitude of a signed weight; the most negative value saturates.
   function automatic logic [LANE_W-1:0] weight_mag(input logic [15:0] w);
      logic [15:0] m;
      m = w[15] ? 16'(~w + 16'd1) : w;
      return m[15] ? {LANE_W{1'b1}} : m[LANE_W-1:0];
   endfunction

   function automatic logic dir_on_grid(input logic [3:0] r, input logic [3:0] c,
                                        input dir_type d);
      logic ok;
      case (d)
         DIR_LEFT:  ok = (c != 4'd0);
         DIR_RIGHT: ok = (({1'b0, c} + 5'd1) < EDGE_LIM);
         DIR_UP:    ok = (r != 4'd0);
         DIR_DOWN:  ok = (({1'b0, r} + 5'd1) < EDGE_LIM);
         default:   ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic cell_inside(input logic [3:0] r, input logic [3:0] c);
      return ({1'b0, r} < EDGE_LIM) && ({1'b0, c} < EDGE_LIM);
   endfunction

endpackage

// File: hw/rtl/gwss_weight_store.sv
// ----------------------------------------------------------------------------
// gwss_weight_store
// Per-cell weight memory: four 15-bit lanes per entry, lane write enables,
// one registered read port.
// ----------------------------------------------------------------------------
module gwss_weight_store
   import gwss_pkg::*;
(
   input  logic                clock,
   input  wr_req_type          wr,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output logic [ENTRY_W-1:0]  rd_data
);

   logic [ENTRY_W-1:0] weight_mem_ff [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int lane = 0; lane < NUM_DIRS; lane++) begin
         if (wr.en && (wr.lane == dir_type'(lane))) begin
            weight_mem_ff[wr.addr][lane*LANE_W +: LANE_W] <= wr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= weight_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gwss_pick.sv
// ----------------------------------------------------------------------------
// gwss_pick
// Compares the scaled running sums against the threshold, picks the first
// direction that clears it and forms the neighbor cell.
// ----------------------------------------------------------------------------
module gwss_pick
   import gwss_pkg::*;
(
   input  pick_op_type   op,
   output pick_res_type  res
);

   logic [CUM_W-1:0]    cum [NUM_DIRS];
   logic [NUM_DIRS-1:0] hit;
   logic                found;
   dir_type             sel;

   assign cum[0] = op.cum0;
   assign cum[1] = op.cum1;
   assign cum[2] = op.cum2;
   assign cum[3] = op.cum3;

   always_comb begin
      for (int k = 0; k < NUM_DIRS; k++) begin
         hit[k] = ({cum[k], 16'd0} > op.thresh);
      end
   end

   // Lowest-numbered hit wins.
   always_comb begin
      found = 1'b0;
      sel   = DIR_LEFT;
      for (int k = NUM_DIRS - 1; k >= 0; k--) begin
         if (hit[k]) begin
            found = 1'b1;
            sel   = dir_type'(k);
         end
      end
   end

   always_comb begin
      res = '0;
      if (op.on_grid && found) begin
         res.moved = 1'b1;
         res.dir   = sel;
         res.row   = op.row;
         res.col   = op.col;
         case (sel)
            DIR_LEFT:  res.col = op.col - 4'd1;
            DIR_RIGHT: res.col = op.col + 4'd1;
            DIR_UP:    res.row = op.row - 4'd1;
            DIR_DOWN:  res.row = op.row + 4'd1;
            default:   res.row = op.row;
         endcase
      end
   end

endmodule

// File: hw/rtl/grid_weighted_step_sampler_top.sv
// ----------------------------------------------------------------------------
// grid_weighted_step_sampler_top
// Roulette-wheel step sampler over a grid of per-cell move weights.
// ----------------------------------------------------------------------------
// The block takes one item per cycle unless a result waits. A load writes one
// weight lane of the cell's memory entry at the clock edge of its transfer and
// gives no result. A step reads the cell's entry from the synchronous weight
// memory, forms the running sums and the threshold product in the next stage,
// compares in the one after, and presents its result in the output register.
// The output register and the two stages in front of it hold while a result
// waits, so req_ready drops only while rsp_valid is high and rsp_ready low.
// A step placed directly behind a load to the same cell sees the new weight,
// since the write lands before the read. The weight memory has no reset.
// ----------------------------------------------------------------------------
module grid_weighted_step_sampler_top
   import gwss_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_command,
   input  logic [3:0]    req_cell_row,
   input  logic [3:0]    req_cell_col,
   input  logic [1:0]    req_move_dir,
   input  logic [15:0]   req_move_weight,
   input  logic [15:0]   req_rand_frac,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_moved,
   output logic [1:0]    rsp_chosen_dir,
   output logic [3:0]    rsp_next_row,
   output logic [3:0]    rsp_next_col
);

   logic               stall;
   logic               req_xfer;
   logic               step_xfer;
   wr_req_type         wr_in;
   logic [ENTRY_W-1:0] rd_data;

   logic               s1_valid_ff, s1_valid_in;
   logic [3:0]         s1_row_ff, s1_col_ff;
   logic               s1_inside_ff;
   logic [FRAC_W-1:0]  s1_frac_ff;

   logic               s2_valid_ff, s2_valid_in;
   pick_op_type        s2_op_ff, s2_op_in;

   logic               out_valid_ff, out_valid_in;
   pick_res_type       out_ff, out_in;

   logic [LANE_W-1:0]  w0, w1, w2, w3;

   assign stall     = out_valid_ff && !rsp_ready;
   assign req_ready = !stall;
   assign req_xfer  = req_valid && req_ready;
   assign step_xfer = req_xfer && (req_command == CMD_STEP);

   // Load path: a direction that leaves the grid stores zero.
   always_comb begin
      wr_in.en   = req_xfer && (req_command == CMD_LOAD)
                   && cell_inside(req_cell_row, req_cell_col);
      wr_in.addr = {req_cell_row, req_cell_col};
      wr_in.lane = dir_type'(req_move_dir);
      wr_in.data = dir_on_grid(req_cell_row, req_cell_col, dir_type'(req_move_dir))
                   ? weight_mag(req_move_weight) : '0;
   end

   gwss_weight_store u_store (
      .clock   (clock),
      .wr      (wr_in),
      .rd_en   (step_xfer),
      .rd_addr ({req_cell_row, req_cell_col}),
      .rd_data (rd_data)
   );

   // Stage 1: running sums and the threshold product.
   assign w0 = rd_data[0*LANE_W +: LANE_W];
   assign w1 = rd_data[1*LANE_W +: LANE_W];
   assign w2 = rd_data[2*LANE_W +: LANE_W];
   assign w3 = rd_data[3*LANE_W +: LANE_W];

   always_comb begin
      s2_op_in         = s2_op_ff;
      s2_op_in.row     = s1_row_ff;
      s2_op_in.col     = s1_col_ff;
      s2_op_in.on_grid = s1_inside_ff;
      s2_op_in.cum0    = CUM_W'(w0);
      s2_op_in.cum1    = s2_op_in.cum0 + CUM_W'(w1);
      s2_op_in.cum2    = s2_op_in.cum1 + CUM_W'(w2);
      s2_op_in.cum3    = s2_op_in.cum2 + CUM_W'(w3);
      s2_op_in.thresh  = PROD_W'(s1_frac_ff) * PROD_W'(s2_op_in.cum3);
   end

   gwss_pick u_pick (
      .op  (s2_op_ff),
      .res (out_in)
   );

   always_comb begin
      s1_valid_in  = stall ? s1_valid_ff : step_xfer;
      s2_valid_in  = stall ? s2_valid_ff : s1_valid_ff;
      out_valid_in = stall ? out_valid_ff : s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_xfer) begin
         s1_row_ff    <= req_cell_row;
         s1_col_ff    <= req_cell_col;
         s1_inside_ff <= cell_inside(req_cell_row, req_cell_col);
         s1_frac_ff   <= req_rand_frac;
      end
      if (!stall) begin
         s2_op_ff <= s2_op_in;
         out_ff   <= out_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_moved      = out_ff.moved;
   assign rsp_chosen_dir = out_ff.dir;
   assign rsp_next_row   = out_ff.row;
   assign rsp_next_col   = out_ff.col;

   // A waiting result blocks new transfers.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted while a result waits");

   // A step in the last stage reaches the output once the pipe advances.
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !stall) |=> rsp_valid)
      else $error("step result lost between last stage and output");

   // A load never enters the step pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_command == CMD_LOAD)) |=> !s1_valid_ff)
      else $error("load item entered step pipeline");

   // A no-move result carries all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_moved) |->
      (rsp_chosen_dir == DIR_LEFT && rsp_next_row == 4'd0 && rsp_next_col == 4'd0))
      else $error("no-move result with nonzero fields");

endmodule
